@@ rtl/assert_macros.svh @@
// assertion macros used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on a clock, disabled while reset is low
`define CTLT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("ctlt assertion failed");

// condition that must never hold
`define CTLT_ASSERT_NEVER(lbl, clk, rstn, cond) \
  `CTLT_ASSERT(lbl, clk, rstn, !(cond))

`endif

@@ rtl/ctlt_pkg.sv @@
// types, constants and helpers of the colour threshold table trainer
`timescale 1ns / 1ps
`default_nettype none

package ctlt_pkg;

  localparam int unsigned LEVELS     = 256;
  localparam int unsigned NUM_CHAN   = 3;
  localparam int unsigned MASK_W     = 8;
  localparam int unsigned VAL_W      = 8;
  localparam int unsigned FUNC_W     = 3;
  localparam int unsigned CLS_W      = 3;
  localparam int unsigned RAD_W      = 9;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned Q_DEPTH    = 2;
  localparam int unsigned OB_DEPTH   = 2;

  localparam logic [FUNC_W-1:0] FUNC_CLASSIFY = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_MARK     = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_ERASE    = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_SAVE     = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_RESTORE  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_CLASS_INDEX  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BRUSH_RADIUS = 1'b1;

  localparam logic [RAD_W-1:0] RADIUS_RESET = 9'd1;

  typedef enum logic [2:0] {
    OP_CLASSIFY,
    OP_MARK,
    OP_ERASE,
    OP_SAVE,
    OP_RESTORE,
    OP_NONE
  } op_e;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_SWEEP
  } bk_state_e;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [VAL_W-1:0]  y_value;
    logic [VAL_W-1:0]  u_value;
    logic [VAL_W-1:0]  v_value;
  } req_t;

  typedef struct packed {
    logic [MASK_W-1:0] class_mask;
    logic              is_member;
  } res_t;

  typedef struct packed {
    op_e                              op;
    logic [NUM_CHAN-1:0][VAL_W-1:0]   val;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } qhead_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } bk_ctrl_t;

  function automatic op_e decode_func(logic [FUNC_W-1:0] func);
    op_e op;
    case (func)
      FUNC_CLASSIFY: op = OP_CLASSIFY;
      FUNC_MARK:     op = OP_MARK;
      FUNC_ERASE:    op = OP_ERASE;
      FUNC_SAVE:     op = OP_SAVE;
      FUNC_RESTORE:  op = OP_RESTORE;
      default:       op = OP_NONE;
    endcase
    return op;
  endfunction

endpackage

`default_nettype wire

@@ rtl/ctlt_ram.sv @@
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module ctlt_ram #(
  parameter int unsigned WIDTH = ctlt_pkg::MASK_W,
  parameter int unsigned DEPTH = ctlt_pkg::LEVELS,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/ctlt_front.sv @@
// front end: takes requests, decodes the function and queues them
`timescale 1ns / 1ps
`default_nettype none

module ctlt_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire ctlt_pkg::req_t     in_req_i,
  output ctlt_pkg::qhead_t        head_o,
  input  wire ctlt_pkg::bk_ctrl_t ctrl_i
);

  localparam int unsigned PW = $clog2(ctlt_pkg::Q_DEPTH);
  localparam int unsigned CW = $clog2(ctlt_pkg::Q_DEPTH + 1);

  ctlt_pkg::item_t entries_q [ctlt_pkg::Q_DEPTH];
  ctlt_pkg::item_t new_item;
  logic [PW-1:0]   wp_q, wp_d, rp_q, rp_d;
  logic [CW-1:0]   count_q, count_d;
  logic            full, push, pop;

  assign full       = count_q == CW'(ctlt_pkg::Q_DEPTH);
  assign in_stall_o = full || ctrl_i.clearing;
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = ctrl_i.pop;

  always_comb begin
    new_item.op     = ctlt_pkg::decode_func(in_req_i.func);
    new_item.val[0] = in_req_i.y_value;
    new_item.val[1] = in_req_i.u_value;
    new_item.val[2] = in_req_i.v_value;
  end

  always_comb begin
    wp_d    = push ? PW'(wp_q + 1'b1) : wp_q;
    rp_d    = pop ? PW'(rp_q + 1'b1) : rp_q;
    count_d = CW'(count_q + CW'(push) - CW'(pop));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      rp_q    <= '0;
      count_q <= '0;
    end else begin
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wp_q] <= new_item;
    end
  end

  assign head_o.valid = count_q != '0;
  assign head_o.item  = entries_q[rp_q];

endmodule

`default_nettype wire

@@ rtl/ctlt_back.sv @@
// back end: table rams, lookup pipeline, table sweeps and result buffer
`timescale 1ns / 1ps
`default_nettype none

module ctlt_back #(
  parameter int unsigned LEVELS = ctlt_pkg::LEVELS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire ctlt_pkg::qhead_t              head_i,
  output ctlt_pkg::bk_ctrl_t                 ctrl_o,
  input  wire logic [ctlt_pkg::CLS_W-1:0]    cls_idx_i,
  input  wire logic [ctlt_pkg::RAD_W-1:0]    radius_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output ctlt_pkg::res_t                     out_res_o
);

  localparam int unsigned NC  = ctlt_pkg::NUM_CHAN;
  localparam int unsigned MW  = ctlt_pkg::MASK_W;
  localparam int unsigned AW  = $clog2(LEVELS);
  localparam int unsigned CW  = AW + 1;
  localparam int unsigned EW  = ((AW > ctlt_pkg::VAL_W) ? AW : ctlt_pkg::VAL_W) + 1;
  localparam int unsigned MX  = (AW > ctlt_pkg::RAD_W) ? AW : ctlt_pkg::RAD_W;
  localparam int unsigned WW  = ((MX > ctlt_pkg::VAL_W) ? MX : ctlt_pkg::VAL_W) + 1;
  localparam int unsigned OPW = $clog2(ctlt_pkg::OB_DEPTH);
  localparam int unsigned OCW = $clog2(ctlt_pkg::OB_DEPTH + 1);

  ctlt_pkg::bk_state_e state_q, state_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  ctlt_pkg::item_t     item_q, item_d;
  logic                wr_pend_q, wr_pend_d;
  logic [AW-1:0]       wr_addr_q, wr_addr_d;
  logic                res_pend_q, res_pend_d;
  logic                res_cls_q, res_cls_d;
  logic [NC-1:0]       ok_q, ok_d;

  logic [NC-1:0]          tab_we;
  logic [AW-1:0]          tab_waddr;
  logic [NC-1:0][MW-1:0]  tab_wdata;
  logic [NC-1:0][AW-1:0]  tab_raddr;
  logic [NC-1:0][MW-1:0]  tab_rdata;
  logic                   undo_we;
  logic [NC-1:0][MW-1:0]  undo_wdata;
  logic [AW-1:0]          undo_raddr;
  logic [NC-1:0][MW-1:0]  undo_rdata;

  logic [NC-1:0][AW-1:0]  head_addr;
  logic [NC-1:0]          head_ok;
  logic [NC-1:0]          in_win;
  logic [MW-1:0]          cls_bit;
  logic                   is_sweep_op, can_issue, issue, fin_ok, sweep_done;

  ctlt_pkg::res_t         ob_q [ctlt_pkg::OB_DEPTH];
  ctlt_pkg::res_t         push_res;
  logic [OPW-1:0]         ob_wp_q, ob_rp_q;
  logic [OCW-1:0]         ob_cnt_q;
  logic                   ob_push, ob_pop;
  logic [OCW:0]           occ, lim;

  for (genvar c = 0; c < NC; c++) begin : g_chan
    ctlt_ram #(.WIDTH(MW), .DEPTH(LEVELS)) u_tab (
      .clk_i   (clk_i),
      .we_i    (tab_we[c]),
      .waddr_i (tab_waddr),
      .wdata_i (tab_wdata[c]),
      .raddr_i (tab_raddr[c]),
      .rdata_o (tab_rdata[c])
    );
    ctlt_ram #(.WIDTH(MW), .DEPTH(LEVELS)) u_undo (
      .clk_i   (clk_i),
      .we_i    (undo_we),
      .waddr_i (tab_waddr),
      .wdata_i (undo_wdata[c]),
      .raddr_i (undo_raddr),
      .rdata_o (undo_rdata[c])
    );
  end

  // table address and range check per component of the queue head
  always_comb begin
    logic [EW-1:0] ext;
    for (int c = 0; c < NC; c++) begin
      ext          = EW'(head_i.item.val[c]);
      head_ok[c]   = ext < EW'(LEVELS);
      head_addr[c] = ext[AW-1:0];
    end
  end

  // brush window of the entry being written back
  always_comb begin
    logic [WW-1:0] k, r, ctr;
    k = WW'(wr_addr_q);
    r = WW'(radius_i);
    for (int c = 0; c < NC; c++) begin
      ctr       = WW'(item_q.val[c]);
      in_win[c] = ((k + r) > ctr) && (k < (ctr + r));
    end
  end

  assign cls_bit     = MW'(1) << cls_idx_i;
  assign is_sweep_op = (head_i.item.op == ctlt_pkg::OP_MARK) ||
                       (head_i.item.op == ctlt_pkg::OP_ERASE) ||
                       (head_i.item.op == ctlt_pkg::OP_SAVE) ||
                       (head_i.item.op == ctlt_pkg::OP_RESTORE);

  assign ob_pop    = out_valid_o && !out_stall_i;
  assign occ       = (OCW+1)'(ob_cnt_q) + (OCW+1)'(res_pend_q);
  assign lim       = (OCW+1)'(ctlt_pkg::OB_DEPTH - 1) + (OCW+1)'(ob_pop);
  assign can_issue = occ <= lim;
  assign issue     = (state_q == ctlt_pkg::BK_IDLE) && head_i.valid && !wr_pend_q &&
                     can_issue;
  assign fin_ok     = (ob_cnt_q != OCW'(ctlt_pkg::OB_DEPTH)) || ob_pop;
  assign sweep_done = (cnt_q == CW'(LEVELS)) && fin_ok;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ctlt_pkg::BK_CLEAR: begin
        if (cnt_q == CW'(LEVELS - 1)) state_d = ctlt_pkg::BK_IDLE;
      end
      ctlt_pkg::BK_IDLE: begin
        if (issue && is_sweep_op) state_d = ctlt_pkg::BK_SWEEP;
      end
      ctlt_pkg::BK_SWEEP: begin
        if (sweep_done) state_d = ctlt_pkg::BK_IDLE;
      end
      default: state_d = ctlt_pkg::BK_CLEAR;
    endcase
  end

  // datapath and control outputs
  always_comb begin
    cnt_d       = '0;
    item_d      = item_q;
    wr_pend_d   = 1'b0;
    wr_addr_d   = cnt_q[AW-1:0];
    res_pend_d  = 1'b0;
    res_cls_d   = res_cls_q;
    ok_d        = ok_q;
    tab_we      = '0;
    tab_wdata   = tab_rdata;
    undo_we     = 1'b0;
    undo_wdata  = tab_rdata;
    tab_waddr   = wr_addr_q;
    undo_raddr  = cnt_q[AW-1:0];
    tab_raddr   = head_addr;
    ctrl_o.pop      = 1'b0;
    ctrl_o.clearing = 1'b0;

    case (state_q)
      ctlt_pkg::BK_CLEAR: begin
        ctrl_o.clearing = 1'b1;
        tab_waddr  = cnt_q[AW-1:0];
        tab_we     = '1;
        tab_wdata  = '0;
        undo_we    = 1'b1;
        undo_wdata = '0;
        if (cnt_q != CW'(LEVELS - 1)) cnt_d = CW'(cnt_q + 1'b1);
      end
      ctlt_pkg::BK_IDLE: begin
        if (issue) begin
          ctrl_o.pop = 1'b1;
          item_d     = head_i.item;
          res_pend_d = !is_sweep_op;
          res_cls_d  = head_i.item.op == ctlt_pkg::OP_CLASSIFY;
          ok_d       = head_ok;
        end
      end
      ctlt_pkg::BK_SWEEP: begin
        for (int c = 0; c < NC; c++) begin
          tab_raddr[c] = cnt_q[AW-1:0];
        end
        if (cnt_q != CW'(LEVELS)) begin
          cnt_d     = CW'(cnt_q + 1'b1);
          wr_pend_d = 1'b1;
        end else if (!sweep_done) begin
          cnt_d = cnt_q;
        end
      end
      default: ;
    endcase

    // write back of the entry read in the previous cycle
    if (wr_pend_q) begin
      case (item_q.op)
        ctlt_pkg::OP_MARK: begin
          tab_we = '1;
          for (int c = 0; c < NC; c++) begin
            if (in_win[c]) tab_wdata[c] = tab_rdata[c] | cls_bit;
          end
        end
        ctlt_pkg::OP_ERASE: begin
          tab_we = '1;
          for (int c = 0; c < NC; c++) begin
            if (in_win[c]) tab_wdata[c] = tab_rdata[c] & ~cls_bit;
          end
        end
        ctlt_pkg::OP_SAVE: begin
          undo_we = 1'b1;
        end
        ctlt_pkg::OP_RESTORE: begin
          tab_we    = '1;
          tab_wdata = undo_rdata;
        end
        default: ;
      endcase
    end
  end

  // result of a lookup or of a finished sweep
  always_comb begin
    logic [MW-1:0] mask;
    mask = '1;
    for (int c = 0; c < NC; c++) begin
      mask = mask & (ok_q[c] ? tab_rdata[c] : '0);
    end
    if (!res_pend_q || !res_cls_q) mask = '0;
    push_res.class_mask = mask;
    push_res.is_member  = mask[cls_idx_i];
    ob_push = res_pend_q || ((state_q == ctlt_pkg::BK_SWEEP) && sweep_done);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ctlt_pkg::BK_CLEAR;
      cnt_q      <= '0;
      wr_pend_q  <= 1'b0;
      res_pend_q <= 1'b0;
      ob_wp_q    <= '0;
      ob_rp_q    <= '0;
      ob_cnt_q   <= '0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      wr_pend_q  <= wr_pend_d;
      res_pend_q <= res_pend_d;
      if (ob_push) ob_wp_q <= OPW'(ob_wp_q + 1'b1);
      if (ob_pop)  ob_rp_q <= OPW'(ob_rp_q + 1'b1);
      ob_cnt_q <= OCW'(ob_cnt_q + OCW'(ob_push) - OCW'(ob_pop));
    end
  end

  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    wr_addr_q <= wr_addr_d;
    res_cls_q <= res_cls_d;
    ok_q      <= ok_d;
    if (ob_push) ob_q[ob_wp_q] <= push_res;
  end

  assign out_valid_o = ob_cnt_q != '0;
  assign out_res_o   = ob_q[ob_rp_q];

endmodule

`default_nettype wire

@@ rtl/color_threshold_lut_trainer_core.sv @@
// top level of the colour threshold table trainer
//
//   channel  direction  handshake                payload
//   in       input      in_valid_i / in_stall_o  in_req_i  (func, y, u, v)
//   out      output     out_valid_o / out_stall_i out_res_o (class_mask, is_member)
//   cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// classify and unused codes: one request per cycle while the result buffer has room
// mark, erase, save, restore: a sweep of all LEVELS entries, one per cycle through the ram ports
// after reset a clearing pass over all LEVELS entries zeroes all tables, in_stall_o high meanwhile
// a two entry request queue and a two entry result buffer decouple the stall of either side
`timescale 1ns / 1ps
`default_nettype none

module color_threshold_lut_trainer_core #(
  parameter int unsigned LEVELS = ctlt_pkg::LEVELS
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire ctlt_pkg::req_t                      in_req_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output ctlt_pkg::res_t                           out_res_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [ctlt_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [ctlt_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  logic [ctlt_pkg::CLS_W-1:0] cls_q, cls_d;
  logic [ctlt_pkg::RAD_W-1:0] rad_q, rad_d;
  ctlt_pkg::qhead_t           head;
  ctlt_pkg::bk_ctrl_t         ctrl;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cls_d = cls_q;
    rad_d = rad_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        ctlt_pkg::CFG_CLASS_INDEX:  cls_d = cfg_data_i[ctlt_pkg::CLS_W-1:0];
        ctlt_pkg::CFG_BRUSH_RADIUS: rad_d = cfg_data_i[ctlt_pkg::RAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cls_q <= '0;
      rad_q <= ctlt_pkg::RADIUS_RESET;
    end else begin
      cls_q <= cls_d;
      rad_q <= rad_d;
    end
  end

  ctlt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .head_o     (head),
    .ctrl_i     (ctrl)
  );

  ctlt_back #(.LEVELS(LEVELS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .ctrl_o      (ctrl),
    .cls_idx_i   (cls_q),
    .radius_i    (rad_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o)
  );

endmodule

`default_nettype wire

@@ rtl/ctlt_checker.sv @@
// port level checker of the colour threshold table trainer and its bind
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ctlt_checker (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  input  wire logic                            in_stall_o,
  input  wire logic                            out_valid_o,
  input  wire logic                            out_stall_i,
  input  wire ctlt_pkg::res_t                  out_res_o
);

  localparam logic [2:0] MAX_OPEN = 3'd5;

  logic [2:0] open_q, open_d;
  logic       acc_in, acc_out;

  assign acc_in  = in_valid_i && !in_stall_o;
  assign acc_out = out_valid_o && !out_stall_i;
  assign open_d  = 3'(open_q + 3'(acc_in) - 3'(acc_out));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else begin
      open_q <= open_d;
    end
  end

  // no result without a request still open
  `CTLT_ASSERT(a_no_phantom, clk_i, rst_ni, out_valid_o |-> (open_q != 3'd0))
  // queue, lookup stage and result buffer bound the open requests
  `CTLT_ASSERT(a_capacity, clk_i, rst_ni, open_q <= MAX_OPEN)
  // membership needs a non-zero mask
  `CTLT_ASSERT_NEVER(a_member_mask, clk_i, rst_ni,
    out_valid_o && out_res_o.is_member && (out_res_o.class_mask == '0))
  // stalled result holds
  `CTLT_ASSERT(a_out_hold, clk_i, rst_ni,
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_res_o)))

endmodule

bind color_threshold_lut_trainer_core ctlt_checker u_checker (.*);

`default_nettype wire
